@@ sv/plsd_pkg.sv @@
`default_nettype none

package plsd_pkg;

  // Sample format codes held in the sample_format register.
  localparam logic [2:0] FMT_S8  = 3'd0;
  localparam logic [2:0] FMT_S16 = 3'd1;
  localparam logic [2:0] FMT_S32 = 3'd2;
  localparam logic [2:0] FMT_U8  = 3'd3;
  localparam logic [2:0] FMT_U16 = 3'd4;
  localparam logic [2:0] FMT_U32 = 3'd5;

  // Configuration register indexes.
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_FORMAT     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SILENCE_THRESHOLD = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SILENCE_LIMIT     = 2'd3;

  // Field and register widths.
  localparam int FMT_W    = 3;
  localparam int CCOUNT_W = 4;
  localparam int CCEXT_W  = 5;
  localparam int THR_W    = 16;
  localparam int LIMIT_W  = 8;
  localparam int CFG_W    = 16;
  localparam int SAMPLE_W = 32;
  localparam int CHIDX_W  = 3;
  localparam int LEVEL_W  = 17;
  localparam int RES_W    = CHIDX_W + LEVEL_W + 2;

  // Divider operand widths: numerator below 2^33, divisor below 2^32. The
  // numerator is scaled by 2^FRAC_W before the division.
  localparam int NUM_W  = 34;
  localparam int DEN_W  = 32;
  localparam int FRAC_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 17'h1FFFF;

  // Reset values of the configuration registers.
  localparam logic [FMT_W-1:0]    RST_FORMAT    = FMT_S16;
  localparam logic [CCOUNT_W-1:0] RST_CCOUNT    = 4'd1;
  localparam logic [THR_W-1:0]    RST_THRESHOLD = 16'd66;
  localparam logic [LIMIT_W-1:0]  RST_LIMIT     = 8'd30;

  // Full-scale constants of the level computation.
  localparam logic [DEN_W-1:0] PEAK_S8  = 32'd127;
  localparam logic [DEN_W-1:0] PEAK_S16 = 32'd32767;
  localparam logic [DEN_W-1:0] PEAK_S32 = 32'd2147483647;
  localparam logic [DEN_W-1:0] FULL_U8  = 32'd255;
  localparam logic [DEN_W-1:0] FULL_U16 = 32'd65535;
  localparam logic [DEN_W-1:0] FULL_U32 = 32'hFFFFFFFF;

  localparam logic [LIMIT_W-1:0] SILENT_MAX = 8'd255;

  // Depths of the snapshot and result queues.
  localparam int SNAP_DEPTH = 2;
  localparam int RES_DEPTH  = 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_RUN,
    S_EMIT
  } back_state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ sv/plsd_fifo.sv @@
`default_nettype none

module plsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/plsd_front.sv @@
`default_nettype none

module plsd_front #(
  parameter int MAX_CHANNELS = 8,
  parameter int POS_W        = 3,
  parameter int CNT_W        = 4
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          push,
  output logic                                               full,
  input  wire logic [plsd_pkg::SAMPLE_W-1:0]                 sample_bits,
  input  wire logic                                          buffer_last,
  input  wire logic [plsd_pkg::FMT_W-1:0]                    sample_format,
  input  wire logic [plsd_pkg::CCOUNT_W-1:0]                 channel_count,
  input  wire logic                                          snap_full,
  output logic                                               snap_push,
  output logic [MAX_CHANNELS-1:0][plsd_pkg::SAMPLE_W-1:0]    snap_peaks,
  output logic [CNT_W-1:0]                                   snap_n,
  output logic [plsd_pkg::FMT_W-1:0]                         snap_fmt
);

  logic [plsd_pkg::SAMPLE_W-1:0] peaks [MAX_CHANNELS];
  logic [POS_W-1:0]              pos;
  logic [POS_W-1:0]              pos_eff;
  logic [POS_W-1:0]              pos_next;
  logic [plsd_pkg::CCEXT_W-1:0]  n_ext;
  logic [plsd_pkg::CCEXT_W-1:0]  pos_inc;
  logic [plsd_pkg::SAMPLE_W-1:0] mag;
  logic [plsd_pkg::SAMPLE_W-1:0] cur;
  logic [plsd_pkg::SAMPLE_W-1:0] upd;
  logic                          accept;

  function automatic logic [plsd_pkg::SAMPLE_W-1:0] magnitude(
    input logic [plsd_pkg::FMT_W-1:0]    fmt,
    input logic [plsd_pkg::SAMPLE_W-1:0] bits
  );
    logic [plsd_pkg::SAMPLE_W-1:0] m;
    case (fmt)
      plsd_pkg::FMT_S8: begin
        m = bits[7] ? 32'(9'h100 - {1'b0, bits[7:0]}) : 32'(bits[7:0]);
      end
      plsd_pkg::FMT_S16: begin
        m = bits[15] ? 32'(17'h10000 - {1'b0, bits[15:0]}) : 32'(bits[15:0]);
      end
      plsd_pkg::FMT_S32: m = bits[31] ? (32'd0 - bits) : bits;
      plsd_pkg::FMT_U8:  m = 32'(bits[7:0]);
      plsd_pkg::FMT_U16: m = 32'(bits[15:0]);
      plsd_pkg::FMT_U32: m = bits;
      default:           m = '0;
    endcase
    return m;
  endfunction

  assign full   = snap_full;
  assign accept = push && !snap_full;

  // Channel count clamped to 1..MAX_CHANNELS.
  always_comb begin
    if (channel_count == '0) begin
      n_ext = plsd_pkg::CCEXT_W'(1);
    end else if ({1'b0, channel_count} > plsd_pkg::CCEXT_W'(MAX_CHANNELS)) begin
      n_ext = plsd_pkg::CCEXT_W'(MAX_CHANNELS);
    end else begin
      n_ext = {1'b0, channel_count};
    end
  end

  always_comb begin
    pos_eff  = (plsd_pkg::CCEXT_W'(pos) >= n_ext) ? '0 : pos;
    pos_inc  = plsd_pkg::CCEXT_W'(pos_eff) + plsd_pkg::CCEXT_W'(1);
    pos_next = (pos_inc >= n_ext) ? '0 : POS_W'(pos_inc);
    mag      = magnitude(sample_format, sample_bits);
    cur      = peaks[pos_eff];
    upd      = (mag > cur) ? mag : cur;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      snap_peaks[i] = (POS_W'(i) == pos_eff) ? upd : peaks[i];
    end
  end

  assign snap_push = accept && buffer_last;
  assign snap_n    = CNT_W'(n_ext);
  assign snap_fmt  = sample_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        peaks[i] <= '0;
      end
    end else if (accept) begin
      pos <= buffer_last ? '0 : pos_next;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        peaks[i] <= buffer_last ? '0 : snap_peaks[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/plsd_divider.sv @@
`default_nettype none

module plsd_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire plsd_pkg::div_req_t req,
  output plsd_pkg::div_rsp_t      rsp
);

  // Every divisor is 2^k - 1. Writing the partial remainder as hi * 2^k + lo
  // gives hi * (2^k - 1) + (hi + lo), so each cycle hi goes into the quotient
  // and hi + lo becomes the new partial remainder. Once it fits in k bits it
  // is at most the divisor, and equal to it only when one more unit is due.
  localparam int SW   = plsd_pkg::NUM_W + plsd_pkg::FRAC_W;
  localparam int SH_W = 6;

  logic                          busy;
  logic                          done;
  logic                          sat;
  logic [SH_W-1:0]               sh;
  logic [SH_W-1:0]               sh_start;
  logic [SW-1:0]                 part;
  logic [plsd_pkg::DEN_W-1:0]    den;
  logic [plsd_pkg::LEVEL_W-1:0]  quo;
  logic [SW-1:0]                 mask;
  logic [SW-1:0]                 hi;
  logic [SW-1:0]                 lo;
  logic                          finish;

  always_comb begin
    case (req.den)
      plsd_pkg::PEAK_S8:  sh_start = SH_W'(7);
      plsd_pkg::PEAK_S16: sh_start = SH_W'(15);
      plsd_pkg::PEAK_S32: sh_start = SH_W'(31);
      plsd_pkg::FULL_U8:  sh_start = SH_W'(8);
      plsd_pkg::FULL_U16: sh_start = SH_W'(16);
      plsd_pkg::FULL_U32: sh_start = SH_W'(32);
      default:            sh_start = SH_W'(1);
    endcase
  end

  assign mask   = SW'(den);
  assign hi     = part >> sh;
  assign lo     = part & mask;
  assign finish = sat || (hi == '0);

  assign rsp.done     = done;
  assign rsp.quotient = sat ? plsd_pkg::LEVEL_MAX : quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      part <= {req.num, {plsd_pkg::FRAC_W{1'b0}}};
      den  <= req.den;
      sh   <= sh_start;
      quo  <= '0;
      // A quotient of 2^17 or more saturates: that is num >= 2 * den.
      sat  <= (req.num >= {1'b0, req.den, 1'b0});
    end else if (busy && !finish) begin
      // Below saturation hi never exceeds the final quotient.
      part <= hi + lo;
      quo  <= quo + plsd_pkg::LEVEL_W'(hi);
    end else if (busy && !sat && (lo == mask)) begin
      quo  <= quo + plsd_pkg::LEVEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && finish;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && finish) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/plsd_back.sv @@
`default_nettype none

module plsd_back #(
  parameter int MAX_CHANNELS = 8,
  parameter int POS_W        = 3,
  parameter int CNT_W        = 4
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        snap_empty,
  input  wire logic [MAX_CHANNELS-1:0][plsd_pkg::SAMPLE_W-1:0] snap_peaks,
  input  wire logic [CNT_W-1:0]                            snap_n,
  input  wire logic [plsd_pkg::FMT_W-1:0]                  snap_fmt,
  output logic                                             snap_pop,
  input  wire logic [plsd_pkg::THR_W-1:0]                  silence_threshold,
  input  wire logic [plsd_pkg::LIMIT_W-1:0]                silence_limit,
  output plsd_pkg::div_req_t                               div_req,
  input  wire plsd_pkg::div_rsp_t                          div_rsp,
  input  wire logic                                        res_full,
  output logic                                             res_push,
  output logic [plsd_pkg::RES_W-1:0]                       res_data
);

  plsd_pkg::back_state_t         state;
  plsd_pkg::back_state_t         state_next;
  logic [POS_W-1:0]              ch;
  logic [POS_W-1:0]              ch_next;
  logic                          stop;
  logic                          stop_next;
  logic [plsd_pkg::LIMIT_W-1:0]  silent_buffers;
  logic [plsd_pkg::LIMIT_W-1:0]  silent_buffers_next;
  logic [plsd_pkg::LIMIT_W-1:0]  silent_inc;
  logic                          res_last;
  logic [plsd_pkg::SAMPLE_W-1:0] peak;
  logic [plsd_pkg::NUM_W-1:0]    twice;
  logic [plsd_pkg::NUM_W-1:0]    full_scale;

  assign peak     = snap_peaks[ch];
  assign res_last = ((CNT_W'(ch) + CNT_W'(1)) == snap_n);
  assign res_data = {plsd_pkg::CHIDX_W'(ch), div_rsp.quotient, stop, res_last};

  // Dividend and divisor of the level for the current channel.
  always_comb begin
    twice      = {1'b0, peak, 1'b0};
    full_scale = '0;
    div_req.start = (state == plsd_pkg::S_START);
    div_req.num   = '0;
    div_req.den   = plsd_pkg::DEN_W'(1);
    case (snap_fmt)
      plsd_pkg::FMT_S8: begin
        div_req.num = plsd_pkg::NUM_W'(peak);
        div_req.den = plsd_pkg::PEAK_S8;
      end
      plsd_pkg::FMT_S16: begin
        div_req.num = plsd_pkg::NUM_W'(peak);
        div_req.den = plsd_pkg::PEAK_S16;
      end
      plsd_pkg::FMT_S32: begin
        div_req.num = plsd_pkg::NUM_W'(peak);
        div_req.den = plsd_pkg::PEAK_S32;
      end
      plsd_pkg::FMT_U8, plsd_pkg::FMT_U16, plsd_pkg::FMT_U32: begin
        if (snap_fmt == plsd_pkg::FMT_U8) begin
          div_req.den = plsd_pkg::FULL_U8;
        end else if (snap_fmt == plsd_pkg::FMT_U16) begin
          div_req.den = plsd_pkg::FULL_U16;
        end else begin
          div_req.den = plsd_pkg::FULL_U32;
        end
        full_scale  = plsd_pkg::NUM_W'(div_req.den);
        div_req.num = (twice >= full_scale) ? (twice - full_scale) : (full_scale - twice);
      end
      default: begin
        div_req.num = '0;
        div_req.den = plsd_pkg::DEN_W'(1);
      end
    endcase
  end

  always_comb begin
    state_next          = state;
    ch_next             = ch;
    stop_next           = stop;
    silent_buffers_next = silent_buffers;
    snap_pop            = 1'b0;
    res_push            = 1'b0;
    silent_inc          = '0;
    case (state)
      plsd_pkg::S_IDLE: begin
        if (!snap_empty) begin
          ch_next    = '0;
          state_next = plsd_pkg::S_START;
        end
      end
      plsd_pkg::S_START: begin
        state_next = plsd_pkg::S_RUN;
      end
      plsd_pkg::S_RUN: begin
        if (div_rsp.done) begin
          state_next = plsd_pkg::S_EMIT;
          if (ch == '0) begin
            // Channel 0 decides silence before any result of the buffer leaves.
            if ({1'b0, silence_threshold} > div_rsp.quotient) begin
              silent_inc = (silent_buffers == plsd_pkg::SILENT_MAX) ?
                           silent_buffers : silent_buffers + plsd_pkg::LIMIT_W'(1);
            end else begin
              silent_inc = '0;
            end
            if (silent_inc > silence_limit) begin
              stop_next           = 1'b1;
              silent_buffers_next = '0;
            end else begin
              stop_next           = 1'b0;
              silent_buffers_next = silent_inc;
            end
          end
        end
      end
      plsd_pkg::S_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (res_last) begin
            snap_pop   = 1'b1;
            state_next = plsd_pkg::S_IDLE;
          end else begin
            ch_next    = ch + POS_W'(1);
            state_next = plsd_pkg::S_START;
          end
        end
      end
      default: begin
        state_next = plsd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= plsd_pkg::S_IDLE;
      ch             <= '0;
      stop           <= 1'b0;
      silent_buffers <= '0;
    end else begin
      state          <= state_next;
      ch             <= ch_next;
      stop           <= stop_next;
      silent_buffers <= silent_buffers_next;
    end
  end

  a_pop_with_last: assert property (@(posedge clk) disable iff (rst)
    snap_pop |-> (res_push && res_last))
    else $error("snapshot released before its last result");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == plsd_pkg::S_RUN))
    else $error("divider finished outside the wait state");

  a_snapshot_held: assert property (@(posedge clk) disable iff (rst)
    (state != plsd_pkg::S_IDLE) |-> !snap_empty)
    else $error("working on a snapshot that is not queued");

  a_next_channel: assert property (@(posedge clk) disable iff (rst)
    (res_push && !res_last) |=>
      ((state == plsd_pkg::S_START) && (ch == $past(ch) + POS_W'(1))))
    else $error("channel sequence broken");

endmodule

`default_nettype wire

@@ sv/peak_level_silence_detector.sv @@
`default_nettype none

// Peak level meter with silence timeout. Interleaved PCM samples are pushed
// one per transfer, and buffer_last marks the final sample of a buffer. The
// front section takes one sample every cycle, keeps a running peak per
// channel and, on the final sample, hands a snapshot of all peaks to a
// two-entry snapshot queue, then clears the peaks. The back section works
// through one snapshot at a time: for each active channel a shared divider
// turns the peak into an unsigned Q1.16 level. Every divisor is one less
// than a power of two, so the divider folds the high bits of the scaled
// dividend back onto the low bits. For each channel the back section
// starts the division, takes its result and hands the result on to the
// result queue, waiting while that queue is full. Channel 0's level
// updates the silent-buffer counter before the first result of the
// buffer is released, so silence_stop is the same on all results of a
// buffer. Results wait in a two-entry result queue, read through empty
// and pop. The full flag rises only while the snapshot queue holds two
// buffers that the back section has not finished; the front then stalls
// every sample until a slot frees up. Configuration is written through
// cfg_write, cfg_index and cfg_data and should only change while the
// block is idle.
module peak_level_silence_detector #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [plsd_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [plsd_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [plsd_pkg::SAMPLE_W-1:0]       sample_bits,
  input  wire logic                                buffer_last,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [plsd_pkg::CHIDX_W-1:0]             channel_index,
  output logic [plsd_pkg::LEVEL_W-1:0]             level,
  output logic                                     silence_stop,
  output logic                                     last_of_run
);

  // Position indexes a channel; the count must also hold MAX_CHANNELS itself.
  localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int SNAP_W = MAX_CHANNELS * plsd_pkg::SAMPLE_W + CNT_W + plsd_pkg::FMT_W;

  // Configuration registers.
  logic [plsd_pkg::FMT_W-1:0]    sample_format;
  logic [plsd_pkg::CCOUNT_W-1:0] channel_count;
  logic [plsd_pkg::THR_W-1:0]    silence_threshold;
  logic [plsd_pkg::LIMIT_W-1:0]  silence_limit;

  // Front to snapshot queue.
  logic                                            snap_push;
  logic                                            snap_full;
  logic [MAX_CHANNELS-1:0][plsd_pkg::SAMPLE_W-1:0] wr_peaks;
  logic [CNT_W-1:0]                                wr_n;
  logic [plsd_pkg::FMT_W-1:0]                      wr_fmt;
  logic [SNAP_W-1:0]                               snap_wdata;

  // Snapshot queue to back.
  logic                                            snap_pop;
  logic                                            snap_empty;
  logic [SNAP_W-1:0]                               snap_rdata;
  logic [MAX_CHANNELS-1:0][plsd_pkg::SAMPLE_W-1:0] rd_peaks;
  logic [CNT_W-1:0]                                rd_n;
  logic [plsd_pkg::FMT_W-1:0]                      rd_fmt;

  // Back to divider and result queue.
  plsd_pkg::div_req_t         div_req;
  plsd_pkg::div_rsp_t         div_rsp;
  logic                       res_push;
  logic                       res_full;
  logic [plsd_pkg::RES_W-1:0] res_wdata;
  logic [plsd_pkg::RES_W-1:0] res_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format     <= plsd_pkg::RST_FORMAT;
      channel_count     <= plsd_pkg::RST_CCOUNT;
      silence_threshold <= plsd_pkg::RST_THRESHOLD;
      silence_limit     <= plsd_pkg::RST_LIMIT;
    end else if (cfg_write) begin
      case (cfg_index)
        plsd_pkg::REG_SAMPLE_FORMAT:     sample_format     <= cfg_data[plsd_pkg::FMT_W-1:0];
        plsd_pkg::REG_CHANNEL_COUNT:     channel_count     <= cfg_data[plsd_pkg::CCOUNT_W-1:0];
        plsd_pkg::REG_SILENCE_THRESHOLD: silence_threshold <= cfg_data[plsd_pkg::THR_W-1:0];
        plsd_pkg::REG_SILENCE_LIMIT:     silence_limit     <= cfg_data[plsd_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  plsd_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .POS_W        (POS_W),
    .CNT_W        (CNT_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .sample_bits   (sample_bits),
    .buffer_last   (buffer_last),
    .sample_format (sample_format),
    .channel_count (channel_count),
    .snap_full     (snap_full),
    .snap_push     (snap_push),
    .snap_peaks    (wr_peaks),
    .snap_n        (wr_n),
    .snap_fmt      (wr_fmt)
  );

  assign snap_wdata = {wr_fmt, wr_n, wr_peaks};
  assign {rd_fmt, rd_n, rd_peaks} = snap_rdata;

  plsd_fifo #(
    .WIDTH (SNAP_W),
    .DEPTH (plsd_pkg::SNAP_DEPTH)
  ) u_snap_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (snap_push),
    .wdata (snap_wdata),
    .full  (snap_full),
    .pop   (snap_pop),
    .rdata (snap_rdata),
    .empty (snap_empty)
  );

  plsd_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .POS_W        (POS_W),
    .CNT_W        (CNT_W)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .snap_empty        (snap_empty),
    .snap_peaks        (rd_peaks),
    .snap_n            (rd_n),
    .snap_fmt          (rd_fmt),
    .snap_pop          (snap_pop),
    .silence_threshold (silence_threshold),
    .silence_limit     (silence_limit),
    .div_req           (div_req),
    .div_rsp           (div_rsp),
    .res_full          (res_full),
    .res_push          (res_push),
    .res_data          (res_wdata)
  );

  plsd_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  plsd_fifo #(
    .WIDTH (plsd_pkg::RES_W),
    .DEPTH (plsd_pkg::RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  // The result word is channel index, level, stop flag and last flag.
  assign {channel_index, level, silence_stop, last_of_run} = res_rdata;

endmodule

`default_nettype wire

@@ tb/plsd_level_checker.sv @@
`timescale 1ns / 100ps

module plsd_level_checker #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [plsd_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [plsd_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               push,
  input  logic                               full,
  input  logic [plsd_pkg::SAMPLE_W-1:0]      sample_bits,
  input  logic                               buffer_last,
  input  logic                               empty,
  input  logic                               pop,
  input  logic [plsd_pkg::CHIDX_W-1:0]       channel_index,
  input  logic [plsd_pkg::LEVEL_W-1:0]       level,
  input  logic                               silence_stop,
  input  logic                               last_of_run,
  output int                                 failures,
  output int                                 pending,
  output int                                 buffers_done,
  output int                                 reports_checked,
  output int                                 stop_buffers
);

  import plsd_pkg::*;

  typedef struct packed {
    logic [CHIDX_W-1:0] chan;
    logic [LEVEL_W-1:0] lvl;
    logic               stop;
    logic               last;
  } level_report_t;

  logic [FMT_W-1:0]    fmt_q;
  logic [CCOUNT_W-1:0] chans_q;
  logic [THR_W-1:0]    thr_q;
  logic [LIMIT_W-1:0]  limit_q;

  logic [SAMPLE_W-1:0] peak_hold [MAX_CHANNELS];
  int unsigned         next_channel;
  logic [LIMIT_W-1:0]  quiet_run;

  level_report_t expected_levels [$];
  int fail_count = 0;
  int buffer_count = 0;
  int report_count = 0;
  int stop_count = 0;

  function automatic int unsigned live_channels(logic [CCOUNT_W-1:0] cc);
    if (cc == 0) return 1;
    if (cc > MAX_CHANNELS) return MAX_CHANNELS;
    return cc;
  endfunction

  // Signed formats hold the magnitude, unsigned formats hold the raw value.
  function automatic logic [SAMPLE_W-1:0] magnitude_of(logic [FMT_W-1:0] f,
                                                      logic [SAMPLE_W-1:0] bits);
    case (f)
      FMT_S8:  return bits[7] ? 32'h100 - {24'b0, bits[7:0]} : {24'b0, bits[7:0]};
      FMT_S16: return bits[15] ? 32'h10000 - {16'b0, bits[15:0]} : {16'b0, bits[15:0]};
      FMT_S32: return bits[31] ? 32'd0 - bits : bits;
      FMT_U8:  return {24'b0, bits[7:0]};
      FMT_U16: return {16'b0, bits[15:0]};
      FMT_U32: return bits;
      default: return '0;
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] level_of_peak(logic [FMT_W-1:0] f,
                                                      logic [SAMPLE_W-1:0] peak);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] twice;
    logic [63:0] q;
    twice = {31'b0, peak, 1'b0};
    case (f)
      FMT_S8:  begin num = 64'(peak); den = 64'(PEAK_S8);  end
      FMT_S16: begin num = 64'(peak); den = 64'(PEAK_S16); end
      FMT_S32: begin num = 64'(peak); den = 64'(PEAK_S32); end
      FMT_U8, FMT_U16, FMT_U32: begin
        den = 64'((f == FMT_U8) ? FULL_U8 : (f == FMT_U16) ? FULL_U16 : FULL_U32);
        num = (twice >= den) ? twice - den : den - twice;
      end
      default: return '0;
    endcase
    q = (num << 16) / den;
    return (q > 64'(LEVEL_MAX)) ? LEVEL_MAX : q[LEVEL_W-1:0];
  endfunction

  always @(posedge clk) begin
    level_report_t got;
    level_report_t want;
    logic [SAMPLE_W-1:0] mag;
    logic stop;
    int unsigned n;
    if (rst) begin
      fmt_q = RST_FORMAT;
      chans_q = RST_CCOUNT;
      thr_q = RST_THRESHOLD;
      limit_q = RST_LIMIT;
      for (int i = 0; i < MAX_CHANNELS; i++) peak_hold[i] = '0;
      next_channel = 0;
      quiet_run = '0;
      expected_levels.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SAMPLE_FORMAT:     fmt_q = cfg_data[FMT_W-1:0];
          REG_CHANNEL_COUNT:     chans_q = cfg_data[CCOUNT_W-1:0];
          REG_SILENCE_THRESHOLD: thr_q = cfg_data[THR_W-1:0];
          REG_SILENCE_LIMIT:     limit_q = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (push && !full) begin
        n = live_channels(chans_q);
        mag = magnitude_of(fmt_q, sample_bits);
        if (next_channel >= n) next_channel = 0;
        if (mag > peak_hold[next_channel]) peak_hold[next_channel] = mag;
        next_channel++;
        if (next_channel >= n) next_channel = 0;

        if (buffer_last) begin
          // Channel 0 decides whether this buffer counts as silent.
          if (level_of_peak(fmt_q, peak_hold[0]) < {1'b0, thr_q}) begin
            if (quiet_run != SILENT_MAX) quiet_run++;
          end else begin
            quiet_run = '0;
          end
          stop = (quiet_run > limit_q);
          if (stop) begin
            quiet_run = '0;
            stop_count++;
          end
          for (int i = 0; i < n; i++) begin
            want.chan = CHIDX_W'(i);
            want.lvl = level_of_peak(fmt_q, peak_hold[i]);
            want.stop = stop;
            want.last = (i == n - 1);
            expected_levels.push_back(want);
          end
          for (int i = 0; i < MAX_CHANNELS; i++) peak_hold[i] = '0;
          next_channel = 0;
          buffer_count++;
        end
      end

      if (pop && !empty) begin
        got = {channel_index, level, silence_stop, last_of_run};
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected level transfer: channel %0d level %0d stop %0b last %0b",
                   $time, got.chan, got.lvl, got.stop, got.last);
          fail_count++;
        end else begin
          want = expected_levels.pop_front();
          report_count++;
          if (got.chan != want.chan) begin
            $display("%0t: channel_index mismatch: expected %0d, actual %0d",
                     $time, want.chan, got.chan);
            fail_count++;
          end
          if (got.lvl != want.lvl) begin
            $display("%0t: level mismatch on channel %0d: expected %0d, actual %0d",
                     $time, want.chan, want.lvl, got.lvl);
            fail_count++;
          end
          if (got.stop != want.stop) begin
            $display("%0t: silence_stop mismatch on channel %0d: expected %0b, actual %0b",
                     $time, want.chan, want.stop, got.stop);
            fail_count++;
          end
          if (got.last != want.last) begin
            $display("%0t: last_of_run mismatch on channel %0d: expected %0b, actual %0b",
                     $time, want.chan, want.last, got.last);
            fail_count++;
          end
        end
      end
    end

    failures <= fail_count;
    pending <= expected_levels.size();
    buffers_done <= buffer_count;
    reports_checked <= report_count;
    stop_buffers <= stop_count;
  end

endmodule

@@ tb/tb_peak_level_silence_detector.sv @@
`timescale 1ns / 100ps

module tb_peak_level_silence_detector;

  import plsd_pkg::*;

  // Cycles to let pass once the last expected level has been seen, so that
  // any work still in flight is over before registers change.
  localparam int SETTLE_CYCLES = 200;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_SAMPLE_FORMAT;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 push = 1'b0;
  logic [SAMPLE_W-1:0]  sample_bits = '0;
  logic                 buffer_last = 1'b0;
  logic                 pop = 1'b0;
  wire                  full;
  wire                  empty;
  wire [CHIDX_W-1:0]    channel_index;
  wire [LEVEL_W-1:0]    level;
  wire                  silence_stop;
  wire                  last_of_run;

  int failures;
  int pending;
  int buffers_done;
  int reports_checked;
  int stop_buffers;

  // When set, neither side idles: pushes go back to back and pop stays high.
  bit steady = 1'b0;
  int samples_sent = 0;
  int settings_used = 0;

  peak_level_silence_detector dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .sample_bits   (sample_bits),
    .buffer_last   (buffer_last),
    .empty         (empty),
    .pop           (pop),
    .channel_index (channel_index),
    .level         (level),
    .silence_stop  (silence_stop),
    .last_of_run   (last_of_run)
  );

  plsd_level_checker level_chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .sample_bits     (sample_bits),
    .buffer_last     (buffer_last),
    .empty           (empty),
    .pop             (pop),
    .channel_index   (channel_index),
    .level           (level),
    .silence_stop    (silence_stop),
    .last_of_run     (last_of_run),
    .failures        (failures),
    .pending         (pending),
    .buffers_done    (buffers_done),
    .reports_checked (reports_checked),
    .stop_buffers    (stop_buffers)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The result side stalls at random, with a chance of 29 in a hundred, except during
  // the steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  // Samples are drawn from a mix of full random words, silence, tiny values
  // on either side of zero, the corner codes of every format, and words with
  // random upper bits that the narrow formats have to ignore.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] corners [12];
    corners = '{32'h0000_007F, 32'h0000_0080, 32'h0000_00FF, 32'h0000_7FFF,
                32'h0000_8000, 32'h0000_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'hFFFF_FFFF, 32'h0000_0081, 32'h0000_8001, 32'h8000_0001};
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return '0;
      2: return $urandom_range(0, 3);
      3: return 32'd0 - $urandom_range(1, 3);
      4: return corners[$urandom_range(0, 11)];
      default: return {16'($urandom_range(0, 65535)), 16'(corners[$urandom_range(0, 11)])};
    endcase
  endfunction

  // One sample transfer. The sender sometimes idles afterwards, now and then
  // long enough to land in the middle of the divider's work.
  task automatic send_sample(input logic [SAMPLE_W-1:0] bits, input logic last);
    push <= 1'b1;
    sample_bits <= bits;
    buffer_last <= last;
    do @(posedge clk); while (full);
    samples_sent++;
    if (!steady && $urandom_range(0, 99) < 29) begin
      push <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(5, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_buffer(input int len);
    for (int k = 0; k < len; k++) send_sample(pick_sample(), k == len - 1);
  endtask

  // Stop sending and wait until every predicted level has come back, then
  // let the block settle so that registers may be changed safely.
  task automatic wait_until_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers on consecutive cycles. The write enable stays
  // high across the burst. Some writes carry junk above the register width,
  // which the block has to drop.
  task automatic apply_settings(input logic [FMT_W-1:0] fmt,
                                input logic [CCOUNT_W-1:0] cc,
                                input logic [THR_W-1:0] thr,
                                input logic [LIMIT_W-1:0] lim);
    logic [CFG_W-1:0]     vals [4];
    logic [REG_IDX_W-1:0] regs [4];
    int                   widths [4];
    logic [CFG_W-1:0]     word;
    vals[0] = CFG_W'(fmt);
    vals[1] = CFG_W'(cc);
    vals[2] = thr;
    vals[3] = CFG_W'(lim);
    regs[0] = REG_SAMPLE_FORMAT;
    regs[1] = REG_CHANNEL_COUNT;
    regs[2] = REG_SILENCE_THRESHOLD;
    regs[3] = REG_SILENCE_LIMIT;
    widths[0] = FMT_W;
    widths[1] = CCOUNT_W;
    widths[2] = THR_W;
    widths[3] = LIMIT_W;
    for (int i = 0; i < 4; i++) begin
      word = vals[i];
      if ($urandom_range(0, 3) == 0) word = word | (CFG_W'($urandom) << widths[i]);
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= word;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int start;
    int r;
    int n;
    logic [FMT_W-1:0]    fmt;
    logic [CCOUNT_W-1:0] cc;
    logic [THR_W-1:0]    thr;
    logic [LIMIT_W-1:0]  lim;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: s16, one channel. Positive and negative full scale,
    // the latter with junk in the upper half, then a silent buffer.
    send_sample(32'h0000_7FFF, 1'b1);
    send_sample(32'hFFFF_8000, 1'b1);
    send_sample(32'h0000_0000, 1'b1);

    // s8 with a channel count of zero (one channel), the highest threshold
    // and a limit of zero, so the first silent buffer raises stop.
    wait_until_drained();
    apply_settings(FMT_S8, 4'd0, 16'hFFFF, 8'd0);
    send_sample(32'h0000_0080, 1'b1);
    send_sample(32'h0000_007F, 1'b1);
    send_sample(32'h0000_0001, 1'b1);

    // u8 with three channels, threshold zero and the saturating limit. The
    // second buffer stops one sample short of a frame, so channel 2 reports
    // the level of an empty peak.
    wait_until_drained();
    apply_settings(FMT_U8, 4'd3, 16'd0, 8'd255);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_00FF, 1'b0);
    send_sample(32'h0000_0080, 1'b1);
    send_sample(32'h0000_007F, 1'b0);
    send_sample(32'h0000_0012, 1'b1);

    // u32 with a channel count above the maximum. Four samples are left
    // open, then the format and the channel count change under them: the
    // position wraps and the old peaks are read as s32.
    wait_until_drained();
    apply_settings(FMT_U32, 4'd15, 16'd66, 8'd30);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    wait_until_drained();
    apply_settings(FMT_S32, 4'd2, 16'd66, 8'd30);
    send_sample(32'h8000_0000, 1'b1);

    // The two unused format codes report zero for everything.
    wait_until_drained();
    apply_settings(3'd6, 4'd2, 16'd66, 8'd30);
    send_sample(32'hDEAD_BEEF, 1'b0);
    send_sample(32'h1234_5678, 1'b1);
    wait_until_drained();
    apply_settings(3'd7, 4'd1, 16'd66, 8'd30);
    send_sample(32'h0000_0001, 1'b1);

    // u16 near mid-scale is silent; with a limit of two the first and fourth
    // buffers raise stop, and each time the count starts over.
    wait_until_drained();
    apply_settings(FMT_U16, 4'd1, 16'd66, 8'd2);
    repeat (4) send_sample(32'h0000_8000, 1'b1);

    // Random part: six settings, at least twenty samples each. Most
    // traffic is whole buffers of one to three frames; the rest is ragged
    // buffers and loose samples with a random last flag. Some rounds leave a
    // buffer open across the next register change. The third round runs
    // without idling.
    for (int round = 0; round < 6; round++) begin
      wait_until_drained();
      fmt = ($urandom_range(0, 9) == 0) ? FMT_W'($urandom_range(6, 7))
                                         : FMT_W'($urandom_range(0, 5));
      r = $urandom_range(0, 19);
      cc = (r == 0) ? 4'd0 : (r == 1) ? CCOUNT_W'($urandom_range(9, 15))
                                      : CCOUNT_W'($urandom_range(1, 8));
      case ($urandom_range(0, 3))
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = THR_W'($urandom_range(0, 65535));
        default: thr = THR_W'($urandom_range(0, 2000));
      endcase
      case ($urandom_range(0, 3))
        0: lim = 8'd255;
        1: lim = LIMIT_W'($urandom_range(0, 255));
        default: lim = LIMIT_W'($urandom_range(0, 4));
      endcase
      apply_settings(fmt, cc, thr, lim);
      steady <= (round == 2);
      n = (cc == 0) ? 1 : (cc > 8) ? 8 : cc;
      start = samples_sent;
      while (samples_sent - start < 20) begin
        r = $urandom_range(0, 99);
        if (r < 10) send_sample(pick_sample(), 1'($urandom_range(0, 1)));
        else if (r < 25) send_buffer($urandom_range(1, 2 * n));
        else send_buffer(n * $urandom_range(1, 3));
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, n + 2)) send_sample(pick_sample(), 1'b0);
      end
    end

    steady <= 1'b0;
    wait_until_drained();
    $display("Run covered %0d samples in %0d buffers under %0d register settings,",
             samples_sent, buffers_done, settings_used);
    $display("and checked %0d level reports; %0d buffers raised silence stop.",
             reports_checked, stop_buffers);
    if (failures == 0 && pending == 0) begin
      $display("tb_peak_level_silence_detector passed");
    end else begin
      $display("tb_peak_level_silence_detector failed");
    end
    $finish;
  end

  // A correct run takes well under a millisecond of simulated time.
  initial begin
    #5_000_000;
    $display("tb_peak_level_silence_detector failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/plsd_pkg.sv
sv/plsd_fifo.sv
sv/plsd_front.sv
sv/plsd_divider.sv
sv/plsd_back.sv
sv/peak_level_silence_detector.sv
tb/plsd_level_checker.sv
tb/tb_peak_level_silence_detector.sv
